// File: design/tnsapf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tnsapf_pkg;

   typedef logic [2:0] step_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_IDLE,
      COND_TAPS
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     issue;
      logic     finish;
      logic     wait_out;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic sample_go;
      logic taps_more;
      logic out_busy;
   } stat_type;

   localparam step_type STEP_WAIT    = 3'd0;
   localparam step_type STEP_MAC     = 3'd1;
   localparam step_type STEP_DRAIN_A = 3'd2;
   localparam step_type STEP_DRAIN_B = 3'd3;
   localparam step_type STEP_FINISH  = 3'd4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_ORDER  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HISTORY_SHIFT = 2'd1;

   localparam int ACC_SHIFT = 31;

   function automatic ctrl_type rom_word(input step_type step);
      ctrl_type w;
      w = '0;
      unique case (step)
         STEP_WAIT: begin
            w.accept = 1'b1;
            w.cond   = COND_IDLE;
            w.target = STEP_WAIT;
         end
         STEP_MAC: begin
            w.issue  = 1'b1;
            w.cond   = COND_TAPS;
            w.target = STEP_MAC;
         end
         STEP_DRAIN_A: begin
            w.cond   = COND_NEXT;
            w.target = STEP_WAIT;
         end
         STEP_DRAIN_B: begin
            w.cond   = COND_NEXT;
            w.target = STEP_WAIT;
         end
         STEP_FINISH: begin
            w.finish   = 1'b1;
            w.wait_out = 1'b1;
            w.cond     = COND_ALWAYS;
            w.target   = STEP_WAIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: design/tnsapf_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tnsapf_seq
   import tnsapf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);

   step_type step_ff;
   step_type step_in;
   ctrl_type word;
   logic     taken;
   logic     stall;

   always_comb begin
      word = rom_word(step_ff);
      unique case (word.cond)
         COND_NEXT:   taken = 1'b0;
         COND_ALWAYS: taken = 1'b1;
         COND_IDLE:   taken = !stat.sample_go;
         COND_TAPS:   taken = stat.taps_more;
         default:     taken = 1'b0;
      endcase
      stall = word.wait_out && stat.out_busy;
      priority if (stall) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = word.target;
      end else begin
         step_in = step_type'(step_ff + 3'd1);
      end
   end

   assign ctrl = word;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tnsapf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tnsapf_dp
   import tnsapf_pkg::*;
#(
   parameter int MAX_ORDER = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ctrl_type                   ctrl,
   output stat_type                        stat,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_action,
   input  wire logic [4:0]                 req_coef_index,
   input  wire logic signed [31:0]         req_data_value,
   input  wire logic                       req_run_start,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [31:0]              rsp_filtered_value,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int CW = $clog2(MAX_ORDER + 1);

   logic signed [31:0] coef_mem [MAX_ORDER];
   logic signed [31:0] hist_mem [MAX_ORDER];

   logic [4:0]         filter_order_ff;
   logic [4:0]         history_shift_ff;
   logic [CW-1:0]      valid_taps_ff;
   logic [CW-1:0]      tap_cnt_ff;
   logic [AW-1:0]      wp_ff;
   logic signed [31:0] sample_ff;
   logic signed [31:0] coef_rd_ff;
   logic signed [31:0] hist_rd_ff;
   logic               rd_vld_ff;
   logic signed [63:0] prod_ff;
   logic               prod_vld_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;

   logic               accept_go;
   logic               load_go;
   logic               sample_go;
   logic               issue_go;
   logic               out_busy;
   logic               finish_go;
   logic               taps_more;
   logic [CW-1:0]      order_cap;
   logic [CW-1:0]      taps_seen;
   logic [CW-1:0]      taps_used;
   logic [CW:0]        wp_ext;
   logic [CW:0]        cnt_ext;
   logic [CW:0]        hist_diff;
   logic [AW-1:0]      hist_addr;
   logic [AW-1:0]      coef_addr;
   logic [AW-1:0]      load_addr;
   logic [64:0]        acc_sum;
   logic signed [31:0] acc_q;
   logic [32:0]        diff;
   logic signed [31:0] y_value;

   assign req_ready = ctrl.accept;
   assign accept_go = req_valid && req_ready;
   assign load_go   = accept_go && !req_action && (req_coef_index != 5'd0)
                      && ({1'b0, req_coef_index} <= 6'(MAX_ORDER));
   assign sample_go = accept_go && req_action;
   assign issue_go  = ctrl.issue && (tap_cnt_ff != '0);
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign finish_go = ctrl.finish && !out_busy;
   assign load_addr = AW'(req_coef_index - 5'd1);
   assign coef_addr = AW'(tap_cnt_ff - CW'(1));
   assign taps_more = tap_cnt_ff > CW'(1);

   assign stat = {sample_go, taps_more, out_busy};

   always_comb begin
      if ({1'b0, filter_order_ff} > 6'(MAX_ORDER)) begin
         order_cap = CW'(MAX_ORDER);
      end else begin
         order_cap = CW'(filter_order_ff);
      end
      taps_seen = req_run_start ? '0 : valid_taps_ff;
      taps_used = (taps_seen < order_cap) ? taps_seen : order_cap;
   end

   always_comb begin
      wp_ext  = (CW + 1)'(wp_ff);
      cnt_ext = (CW + 1)'(tap_cnt_ff);
      if (cnt_ext > wp_ext) begin
         hist_diff = (CW + 1)'(wp_ext + (CW + 1)'(MAX_ORDER) - cnt_ext);
      end else begin
         hist_diff = (CW + 1)'(wp_ext - cnt_ext);
      end
      hist_addr = AW'(hist_diff);
   end

   // accumulate with saturation
   always_comb begin
      acc_sum = {acc_ff[63], acc_ff} + {prod_ff[63], prod_ff};
      if (acc_sum[64] != acc_sum[63]) begin
         acc_in = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_in = acc_sum[63:0];
      end
   end

   always_comb begin
      acc_q = acc_ff[ACC_SHIFT+31:ACC_SHIFT];
      diff  = {sample_ff[31], sample_ff} - {acc_q[31], acc_q};
      if (diff[32] != diff[31]) begin
         y_value = diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
         y_value = diff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_go) begin
         coef_mem[load_addr] <= req_data_value;
      end
      if (issue_go) begin
         coef_rd_ff <= coef_mem[coef_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         hist_mem[wp_ff] <= y_value <<< history_shift_ff;
      end
      if (issue_go) begin
         hist_rd_ff <= hist_mem[hist_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sample_go) begin
         sample_ff <= req_data_value;
      end
      if (rd_vld_ff) begin
         prod_ff <= coef_rd_ff * hist_rd_ff;
      end
      if (finish_go) begin
         rsp_value_ff <= y_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_order_ff  <= 5'd1;
         history_shift_ff <= 5'd1;
         valid_taps_ff    <= '0;
         tap_cnt_ff       <= '0;
         wp_ff            <= '0;
         rd_vld_ff        <= 1'b0;
         prod_vld_ff      <= 1'b0;
         acc_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == CSR_FILTER_ORDER) begin
            filter_order_ff <= csr_data;
         end
         if (csr_write_enable && csr_index == CSR_HISTORY_SHIFT) begin
            history_shift_ff <= csr_data;
         end
         rd_vld_ff   <= issue_go;
         prod_vld_ff <= rd_vld_ff;
         priority if (sample_go) begin
            tap_cnt_ff <= taps_used;
            acc_ff     <= '0;
            if (req_run_start) begin
               valid_taps_ff <= '0;
            end
         end else begin
            if (issue_go) begin
               tap_cnt_ff <= CW'(tap_cnt_ff - CW'(1));
            end
            if (prod_vld_ff) begin
               acc_ff <= acc_in;
            end
         end
         if (finish_go) begin
            wp_ff <= (wp_ff == AW'(MAX_ORDER - 1)) ? '0 : AW'(wp_ff + AW'(1));
            if (valid_taps_ff < CW'(MAX_ORDER)) begin
               valid_taps_ff <= CW'(valid_taps_ff + CW'(1));
            end
         end
         priority if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;

endmodule

`default_nettype wire

// File: design/tns_all_pole_filter.sv
// All-pole temporal noise shaping filter over a run of 32-bit spectral lines.
// Input channel req_*: an item with req_action low loads req_data_value as the
// Q31 coefficient of tap req_coef_index (1..MAX_ORDER, others dropped) and gives
// no result; an item with req_action high filters req_data_value as one sample
// and gives one result on rsp_filtered_value. req_run_start marks a new run.
// csr_* writes filter_order (index 0) and history_shift (index 1); the user
// must write them only while idle, as the block does not enforce it. Loads are
// taken one per cycle while no sample is in progress. A sample with n taps in
// use (n = min of filter_order, MAX_ORDER and samples seen in the run) runs
// through a microcoded sequencer: one tap per cycle through the coefficient
// and history memories and a registered 32x32 multiplier, then two drain steps
// for the multiply and accumulate stages. The result is registered in the
// finish step, and the next item can be accepted in the wait step after it.
// A result still held by a stalled receiver when the next sample reaches its
// final step keeps the sequencer there; that sample completes as soon as the
// held result is taken.
// Reset sets filter_order and history_shift to 1, marks the history empty and
// leaves coefficients unwritten; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module tns_all_pole_filter
   import tnsapf_pkg::*;
#(
   parameter int MAX_ORDER = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_action,
   input  wire logic [4:0]                 req_coef_index,
   input  wire logic signed [31:0]         req_data_value,
   input  wire logic                       req_run_start,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [31:0]              rsp_filtered_value,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   ctrl_type ctrl;
   stat_type stat;

   tnsapf_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   tnsapf_dp #(
      .MAX_ORDER (MAX_ORDER)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .stat               (stat),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_coef_index     (req_coef_index),
      .req_data_value     (req_data_value),
      .req_run_start      (req_run_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

`ifndef NO_ASSERTIONS
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.accept, ctrl.issue, ctrl.finish}))
      else $error("control word drives more than one action");

   a_sample_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action) |=> !req_ready)
      else $error("item accepted while a sample is in progress");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.finish))
      else $error("result raised outside the finish step");

   a_taps_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |-> !stat.taps_more)
      else $error("taps left over while waiting for an item");
`endif

endmodule

`default_nettype wire

// File: sim/tns_all_pole_filter_test.sv
`timescale 1ns / 1ps

module tns_all_pole_filter_test;
   import tnsapf_pkg::*;

   localparam int MAX_TAPS = 16;
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_FILTER = 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 2'd3;
   localparam logic signed [63:0] ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   typedef struct {
      logic              action;
      logic [4:0]        coef_index;
      logic signed [31:0] data_value;
      logic              run_start;
   } filter_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic [4:0] req_coef_index = '0;
   logic signed [31:0] req_data_value = '0;
   logic req_run_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_filtered_value;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   filter_item_t pending_items[$];
   logic signed [31:0] expected_filtered[$];
   int items_outstanding = 0;
   int fail_count = 0;
   int tx_idle_pct = 37;
   int rx_idle_pct = 60;
   int results_seen = 0;
   int stall_left = 0;

   logic signed [31:0] coef_model[MAX_TAPS];
   logic signed [31:0] history_model[MAX_TAPS];
   int taps_seen = 0;
   logic [4:0] order_model = 5'd1;
   logic [4:0] shift_model = 5'd1;

   tns_all_pole_filter #(.MAX_ORDER(MAX_TAPS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_coef_index(req_coef_index),
      .req_data_value(req_data_value),
      .req_run_start(req_run_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_filtered_value(rsp_filtered_value),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63])
         return s[64] ? ACC_MIN : ACC_MAX;
      return s[63:0];
   endfunction

   function automatic void filter_model(input filter_item_t it);
      logic signed [63:0] acc;
      logic signed [63:0] h;
      logic signed [63:0] c;
      logic signed [63:0] shifted;
      logic signed [31:0] q;
      logic signed [32:0] d;
      logic signed [31:0] y;
      int order;
      int n;
      acc = '0;
      if (it.action == ACT_LOAD) begin
         if (it.coef_index >= 1 && it.coef_index <= MAX_TAPS)
            coef_model[it.coef_index - 1] = it.data_value;
         return;
      end
      if (it.run_start)
         taps_seen = 0;
      order = (order_model > MAX_TAPS) ? MAX_TAPS : order_model;
      n = (taps_seen < order) ? taps_seen : order;
      for (int k = n; k > 0; k--) begin
         h = {{32{history_model[k-1][31]}}, history_model[k-1]};
         c = {{32{coef_model[k-1][31]}}, coef_model[k-1]};
         acc = sat_add64(acc, h * c);
      end
      shifted = acc >>> ACC_SHIFT;
      q = shifted[31:0];
      d = {it.data_value[31], it.data_value} - {q[31], q};
      if (d[32] != d[31])
         y = d[32] ? WORD_MIN : WORD_MAX;
      else
         y = d[31:0];
      for (int k = MAX_TAPS - 1; k > 0; k--)
         history_model[k] = history_model[k-1];
      history_model[0] = y << shift_model;
      if (taps_seen < MAX_TAPS)
         taps_seen++;
      expected_filtered.push_back(y);
   endfunction

   always @(posedge clock) begin : driver
      filter_item_t nxt;
      filter_item_t took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            took.action = req_action;
            took.coef_index = req_coef_index;
            took.data_value = req_data_value;
            took.run_start = req_run_start;
            filter_model(took);
            items_outstanding--;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               nxt = pending_items.pop_front();
               req_valid <= 1'b1;
               req_action <= nxt.action;
               req_coef_index <= nxt.coef_index;
               req_data_value <= nxt.data_value;
               req_run_start <= nxt.run_start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic signed [31:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_filtered.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d",
                        $time, rsp_filtered_value);
               fail_count++;
            end else begin
               want = expected_filtered.pop_front();
               if (rsp_filtered_value !== want) begin
                  $display("%0t: filtered_value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_filtered_value);
                  fail_count++;
               end
            end
            results_seen++;
            if (results_seen == 150 || results_seen == 380)
               stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(3))
         0: return $urandom();
         1: return int'($urandom_range(2000)) - 1000;
         2: return $urandom_range(1) ? WORD_MAX : WORD_MIN;
         default: return $signed($urandom()) >>> 8;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_coef();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $signed($urandom()) >>> 4;
         2: return $urandom_range(1) ? WORD_MAX : WORD_MIN;
         default: return $signed($urandom()) >>> 12;
      endcase
   endfunction

   task automatic queue_item(input logic action, input logic [4:0] idx,
                             input logic signed [31:0] value, input logic start);
      filter_item_t it;
      it.action = action;
      it.coef_index = idx;
      it.data_value = value;
      it.run_start = start;
      items_outstanding++;
      pending_items.push_back(it);
   endtask

   task automatic queue_runs(input int samples_wanted);
      int made;
      int run_len;
      made = 0;
      while (made < samples_wanted) begin
         run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(20, 1);
         for (int k = 0; k < run_len && made < samples_wanted; k++) begin
            if ($urandom_range(99) < 8)
               queue_item(ACT_LOAD, 5'($urandom_range(31)), pick_coef(),
                          1'($urandom_range(1)));
            queue_item(ACT_FILTER, 5'($urandom_range(31)), pick_sample(),
                       (k == 0) || ($urandom_range(99) < 3));
            made++;
         end
      end
   endtask

   task automatic settle();
      while (items_outstanding != 0 || expected_filtered.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx == CSR_FILTER_ORDER)
         order_model = value;
      else if (idx == CSR_HISTORY_SHIFT)
         shift_model = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         coef_model[k] = '0;
         history_model[k] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_item(ACT_LOAD, 5'd1, WORD_MAX, 1'b1);
      queue_item(ACT_LOAD, 5'd2, WORD_MIN, 1'b0);
      queue_item(ACT_LOAD, 5'd3, 32'sd0, 1'b1);
      for (int k = 4; k <= MAX_TAPS; k++)
         queue_item(ACT_LOAD, 5'(k), pick_coef(), 1'($urandom_range(1)));
      queue_item(ACT_LOAD, 5'd0, 32'sh1234_5678, 1'b0);
      queue_item(ACT_LOAD, 5'd17, 32'sh5555_aaaa, 1'b1);
      queue_item(ACT_LOAD, 5'd31, 32'shffff_ffff, 1'b0);
      queue_item(ACT_FILTER, 5'd31, WORD_MAX, 1'b1);
      queue_item(ACT_FILTER, 5'd0, WORD_MIN, 1'b0);
      queue_item(ACT_FILTER, 5'd16, 32'sd0, 1'b0);
      queue_item(ACT_FILTER, 5'd1, -32'sd1, 1'b0);
      queue_item(ACT_FILTER, 5'd17, WORD_MIN, 1'b1);
      queue_item(ACT_FILTER, 5'd5, 32'sd12345, 1'b0);
      settle();

      write_reg(CSR_FILTER_ORDER, 5'd0);
      write_reg(CSR_HISTORY_SHIFT, 5'd0);
      write_reg(CSR_SPARE_A, 5'd31);
      write_reg(CSR_SPARE_B, 5'd31);
      queue_runs(60);
      settle();

      write_reg(CSR_FILTER_ORDER, 5'd16);
      write_reg(CSR_HISTORY_SHIFT, 5'd31);
      queue_runs(70);
      settle();

      tx_idle_pct = 60;
      rx_idle_pct = 37;
      write_reg(CSR_FILTER_ORDER, 5'd31);
      write_reg(CSR_HISTORY_SHIFT, 5'd0);
      queue_runs(70);
      settle();

      write_reg(CSR_FILTER_ORDER, 5'd4);
      write_reg(CSR_HISTORY_SHIFT, 5'd3);
      queue_runs(70);
      settle();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_reg(CSR_FILTER_ORDER, 5'($urandom_range(MAX_TAPS, 1)));
      write_reg(CSR_HISTORY_SHIFT, 5'($urandom_range(31)));
      queue_runs(80);
      settle();

      write_reg(CSR_FILTER_ORDER, 5'd16);
      write_reg(CSR_HISTORY_SHIFT, 5'd1);
      queue_runs(50);
      settle();

      repeat (40) @(posedge clock);
      if (expected_filtered.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_filtered.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
design/tnsapf_pkg.sv
design/tnsapf_seq.sv
design/tnsapf_dp.sv
design/tns_all_pole_filter.sv
sim/tns_all_pole_filter_test.sv
